@@ hdl/lefr_pkg.sv @@
// Shared types, constants and the per-channel Laplacian function for the RGB edge filter.
package lefr_pkg;

   // Pixel and configuration widths
   localparam int PIX_W   = 24;
   localparam int CHAN_W  = 8;
   localparam int LINE_W  = 2 * PIX_W;
   localparam int CFG_W   = 12;
   localparam int ROW_W   = 12;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
   localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

   // Input opcodes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Result queue geometry
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;
   localparam int OUT_LVL_W = 3;

   // Control carried from the read stage to the compute stage
   typedef struct packed {
      logic valid;     // effective transaction in the compute stage
      logic write;     // pixel: write back the line memory
      logic emit;      // produces a result
      logic has_up;
      logic has_down;
      logic has_left;
      logic has_right;
      logic eof;
      logic fwd_lo;    // entry at column was being written during the read
      logic fwd_hi;    // entry at column+1 was being written during the read
   } s1_ctl_type;

   // One result transaction
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              eof;
   } rsp_type;

   // 4*center minus the present neighbors, wrapping modulo 256
   function automatic logic [CHAN_W-1:0] lap_chan(
      input logic [CHAN_W-1:0] ctr,
      input logic [CHAN_W-1:0] up,
      input logic [CHAN_W-1:0] down,
      input logic [CHAN_W-1:0] left,
      input logic [CHAN_W-1:0] right
   );
      logic [CHAN_W-1:0] acc;
      acc = {ctr[CHAN_W-3:0], 2'b00};
      acc = acc - up;
      acc = acc - down;
      acc = acc - left;
      acc = acc - right;
      return acc;
   endfunction

endpackage

@@ hdl/laplacian_edge_filter_rgb.sv @@
// Results pass the compute-stage register and the result queue. Throughput: one transaction
// per cycle while req_ready is high, set by the line memory (two reads, one write a cycle).
// Pixels of the last row are drained by flush transactions, one result each.
// Reset clears the counters and the result queue and loads width 640, height 480;
// the line memory is not cleared, every entry is written before its value is used.
module laplacian_edge_filter_rgb #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   // pixel input
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_opcode,
   input  logic [lefr_pkg::CHAN_W-1:0]      req_red_in,
   input  logic [lefr_pkg::CHAN_W-1:0]      req_green_in,
   input  logic [lefr_pkg::CHAN_W-1:0]      req_blue_in,
   // filtered output
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lefr_pkg::CHAN_W-1:0]      rsp_red_out,
   output logic [lefr_pkg::CHAN_W-1:0]      rsp_green_out,
   output logic [lefr_pkg::CHAN_W-1:0]      rsp_blue_out,
   output logic                             rsp_end_of_frame,
   // configuration
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lefr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lefr_pkg::CFG_W-1:0]       csr_data
);

   import lefr_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = AW + 1;

   // Width with zero read as one and large values held at the buffer size
   function automatic logic [WW-1:0] clamp_width(input logic [CFG_W-1:0] value);
      logic [WW-1:0] result;
      if (value == '0) begin
         result = WW'(1);
      end else if (32'(value) > 32'(MAX_WIDTH)) begin
         result = WW'(MAX_WIDTH);
      end else begin
         result = WW'(value);
      end
      return result;
   endfunction

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [AW-1:0]     col_ff, col_in;
   logic [WW-1:0]     w_eff_ff, w_eff_in;
   logic [ROW_W-1:0]  h_eff_ff, h_eff_in;
   s1_ctl_type        s1_ctl_ff, s1_ctl_in;
   logic [AW-1:0]     s1_addr_ff;
   logic [PIX_W-1:0]  s1_pix_ff;

   logic              drain;
   logic              last_col;
   logic              is_pixel;
   logic              take_item;
   logic [AW-1:0]     rd_addr_hi;
   logic [LINE_W-1:0] ram_rdata_lo;
   logic [LINE_W-1:0] ram_rdata_hi;
   logic              wr_en;
   logic [LINE_W-1:0] wr_data;
   rsp_type           res;
   logic              res_valid;
   rsp_type           fifo_data;
   logic [OUT_LVL_W-1:0] fifo_level;
   logic [OUT_LVL_W-1:0] in_flight;

   // Frame position and transaction qualification
   assign drain      = (row_ff >= h_eff_ff);
   assign last_col   = ((WW'(col_ff) + WW'(1)) >= w_eff_ff);
   assign is_pixel   = (req_opcode == OP_PIXEL);
   assign rd_addr_hi = col_ff + AW'(1);

   // Accept while the queue can take every result still in the pipeline
   assign in_flight = fifo_level + OUT_LVL_W'(s1_ctl_ff.valid & s1_ctl_ff.emit);
   assign req_ready = (in_flight < OUT_LVL_W'(OUT_DEPTH));
   assign csr_ready = 1'b1;

   // A pixel after the whole frame, or a flush before it, does nothing
   assign take_item = req_valid & req_ready & (is_pixel ? !drain : drain);

   // Counters and configuration
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      w_eff_in = w_eff_ff;
      h_eff_in = h_eff_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               w_eff_in = clamp_width(csr_data);
               row_in   = '0;
               col_in   = '0;
            end
            CSR_FRAME_HEIGHT: begin
               h_eff_in = (csr_data == '0) ? ROW_W'(1) : csr_data;
               row_in   = '0;
               col_in   = '0;
            end
            default: begin
               row_in = row_ff;
            end
         endcase
      end else if (take_item) begin
         if (last_col) begin
            col_in = '0;
            row_in = is_pixel ? (row_ff + ROW_W'(1)) : '0;
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   // Control for the compute stage
   always_comb begin
      s1_ctl_in.valid     = take_item;
      s1_ctl_in.write     = is_pixel;
      s1_ctl_in.emit      = !is_pixel || (row_ff != '0);
      s1_ctl_in.has_up    = is_pixel ? (row_ff >= ROW_W'(2)) : (h_eff_ff >= ROW_W'(2));
      s1_ctl_in.has_down  = is_pixel;
      s1_ctl_in.has_left  = (col_ff != '0);
      s1_ctl_in.has_right = !last_col;
      s1_ctl_in.eof       = !is_pixel && last_col;
      s1_ctl_in.fwd_lo    = wr_en && (s1_addr_ff == col_ff);
      s1_ctl_in.fwd_hi    = wr_en && (s1_addr_ff == rd_addr_hi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         col_ff    <= '0;
         w_eff_ff  <= clamp_width(RESET_WIDTH);
         h_eff_ff  <= RESET_HEIGHT;
         s1_ctl_ff <= '0;
      end else begin
         row_ff    <= row_in;
         col_ff    <= col_in;
         w_eff_ff  <= w_eff_in;
         h_eff_ff  <= h_eff_in;
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   // Payload of the compute stage
   always_ff @(posedge clock) begin
      if (take_item) begin
         s1_addr_ff <= col_ff;
         s1_pix_ff  <= {req_red_in, req_green_in, req_blue_in};
      end
   end

   // Upper and center lines share one entry per column
   lefr_line_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW),
      .DW    (LINE_W)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (s1_addr_ff),
      .wr_data   (wr_data),
      .rd_en     (take_item),
      .rd_addr_a (col_ff),
      .rd_addr_b (rd_addr_hi),
      .rd_data_a (ram_rdata_lo),
      .rd_data_b (ram_rdata_hi)
   );

   lefr_kernel u_kernel (
      .clock     (clock),
      .ctl       (s1_ctl_ff),
      .pix       (s1_pix_ff),
      .rdata_lo  (ram_rdata_lo),
      .rdata_hi  (ram_rdata_hi[PIX_W-1:0]),
      .res       (res),
      .res_valid (res_valid),
      .wr_en     (wr_en),
      .wr_data   (wr_data)
   );

   lefr_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .pop_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (fifo_data),
      .level     (fifo_level)
   );

   assign rsp_red_out      = fifo_data.red;
   assign rsp_green_out    = fifo_data.green;
   assign rsp_blue_out     = fifo_data.blue;
   assign rsp_end_of_frame = fifo_data.eof;

`ifndef SYNTH
   // Column counter stays inside the frame
   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      (WW'(col_ff) < w_eff_ff))
      else $error("column counter beyond frame width");

   // Row counter never passes the frame height
   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= h_eff_ff))
      else $error("row counter beyond frame height");

   // Line memory is only written for pixels taken before the frame was complete
   a_write_before_drain: assert property (@(posedge clock) disable iff (reset)
      (s1_ctl_ff.valid && s1_ctl_ff.write) |-> $past(row_ff < h_eff_ff))
      else $error("line write after the frame was complete");

   // Admission credit keeps the result queue from overflowing
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(res_valid && (fifo_level == OUT_LVL_W'(OUT_DEPTH)) && !(rsp_valid && rsp_ready)))
      else $error("result queue overflow");
`endif

endmodule

@@ hdl/lefr_line_ram.sv @@
// Line memory: one write port and two registered read ports.
module lefr_line_ram #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11,
   parameter int DW    = 48
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [DW-1:0] rd_data_a,
   output logic [DW-1:0] rd_data_b
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_a_ff;
   logic [DW-1:0] rd_data_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ hdl/lefr_kernel.sv @@
// Compute stage: forwarding, neighbor selection, per-channel filter and write-back data.
module lefr_kernel (
   input  logic                     clock,
   input  lefr_pkg::s1_ctl_type     ctl,
   input  logic [lefr_pkg::PIX_W-1:0]  pix,
   input  logic [lefr_pkg::LINE_W-1:0] rdata_lo,
   input  logic [lefr_pkg::PIX_W-1:0]  rdata_hi,
   output lefr_pkg::rsp_type        res,
   output logic                     res_valid,
   output logic                     wr_en,
   output logic [lefr_pkg::LINE_W-1:0] wr_data
);

   import lefr_pkg::*;

   logic [LINE_W-1:0] last_wr_ff;
   logic [PIX_W-1:0]  left_ff;
   logic [LINE_W-1:0] word_lo;
   logic [PIX_W-1:0]  upper;
   logic [PIX_W-1:0]  center;
   logic [PIX_W-1:0]  right;
   logic [PIX_W-1:0]  nb_up;
   logic [PIX_W-1:0]  nb_down;
   logic [PIX_W-1:0]  nb_left;
   logic [PIX_W-1:0]  nb_right;

   // Memory data, patched with the write that overlapped the read
   assign word_lo = ctl.fwd_lo ? last_wr_ff : rdata_lo;
   assign upper   = word_lo[LINE_W-1:PIX_W];
   assign center  = word_lo[PIX_W-1:0];
   assign right   = ctl.fwd_hi ? last_wr_ff[PIX_W-1:0] : rdata_hi;

   // Neighbors outside the frame count as zero
   assign nb_up    = ctl.has_up    ? upper   : '0;
   assign nb_down  = ctl.has_down  ? pix     : '0;
   assign nb_left  = ctl.has_left  ? left_ff : '0;
   assign nb_right = ctl.has_right ? right   : '0;

   always_comb begin
      res.red   = lap_chan(center[23:16], nb_up[23:16], nb_down[23:16],
                           nb_left[23:16], nb_right[23:16]);
      res.green = lap_chan(center[15:8], nb_up[15:8], nb_down[15:8],
                           nb_left[15:8], nb_right[15:8]);
      res.blue  = lap_chan(center[7:0], nb_up[7:0], nb_down[7:0],
                           nb_left[7:0], nb_right[7:0]);
      res.eof   = ctl.eof;
   end

   assign res_valid = ctl.valid & ctl.emit;

   // Old center moves to the upper line, the new pixel becomes center
   assign wr_en   = ctl.valid & ctl.write;
   assign wr_data = {center, pix};

   // Last write kept for forwarding; center kept as next column's left neighbor
   always_ff @(posedge clock) begin
      if (wr_en) begin
         last_wr_ff <= wr_data;
      end
      if (ctl.valid) begin
         left_ff <= center;
      end
   end

endmodule

@@ hdl/lefr_out_fifo.sv @@
// Result queue that decouples the filter pipeline from the result channel.
module lefr_out_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  lefr_pkg::rsp_type             push_data,
   input  logic                          pop_ready,
   output logic                          out_valid,
   output lefr_pkg::rsp_type             out_data,
   output logic [lefr_pkg::OUT_LVL_W-1:0] level
);

   import lefr_pkg::*;

   rsp_type              slot_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff;
   logic [OUT_PTR_W-1:0] rd_ptr_ff;
   logic [OUT_LVL_W-1:0] count_ff;
   logic                 pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid & pop_ready;
   assign level     = count_ff;

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OUT_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OUT_PTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + OUT_LVL_W'(1);
            2'b01:   count_ff <= count_ff - OUT_LVL_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ tb/edge_filter_checker.sv @@
// Checker for the RGB Laplacian edge filter: predicts every filtered pixel and compares results.
`timescale 1ns / 100ps

module edge_filter_checker #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_opcode,
   input  logic [lefr_pkg::CHAN_W-1:0]    req_red_in,
   input  logic [lefr_pkg::CHAN_W-1:0]    req_green_in,
   input  logic [lefr_pkg::CHAN_W-1:0]    req_blue_in,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [lefr_pkg::CHAN_W-1:0]    rsp_red_out,
   input  logic [lefr_pkg::CHAN_W-1:0]    rsp_green_out,
   input  logic [lefr_pkg::CHAN_W-1:0]    rsp_blue_out,
   input  logic                           rsp_end_of_frame,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [lefr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lefr_pkg::CFG_W-1:0]     csr_data,
   output int                             fail_count,
   output int                             expected_left
);

   import lefr_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // Line buffers of the predictor: previous row and current row
   bit   [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   bit   [PIX_W-1:0] center_mem [MAX_WIDTH];
   logic [ROW_W-1:0] in_row;
   logic [ROW_W-1:0] in_col;
   logic [ROW_W-1:0] out_col;
   logic [PIX_W-1:0] left_ctr;   // old center entry left of the input column
   logic [CFG_W-1:0] cfg_width;
   logic [CFG_W-1:0] cfg_height;

   rsp_type filtered_q[$];
   int      fault_cnt = 0;

   function automatic int frame_w();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic int frame_h();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   // 4*center minus neighbors, mod 256; absent neighbors are passed as zero
   function automatic logic [CHAN_W-1:0] lap8(input logic [CHAN_W-1:0] c, u, d, l, r);
      return (c << 2) - u - d - l - r;
   endfunction

   function automatic rsp_type lap_pixel(input logic [PIX_W-1:0] c, u, d, l, r,
                                         input logic eof);
      rsp_type res;
      res.red   = lap8(c[16 +: 8], u[16 +: 8], d[16 +: 8], l[16 +: 8], r[16 +: 8]);
      res.green = lap8(c[8 +: 8], u[8 +: 8], d[8 +: 8], l[8 +: 8], r[8 +: 8]);
      res.blue  = lap8(c[0 +: 8], u[0 +: 8], d[0 +: 8], l[0 +: 8], r[0 +: 8]);
      res.eof   = eof;
      return res;
   endfunction

   function automatic void restart_frame();
      in_row   = '0;
      in_col   = '0;
      out_col  = '0;
      left_ctr = '0;
   endfunction

   // Pixel transaction: completes the pixel above it, if any
   task automatic apply_pixel(input logic [PIX_W-1:0] pix);
      int               w;
      int               h;
      logic [ROW_W-1:0] ic;
      logic [PIX_W-1:0] old;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] lf;
      logic [PIX_W-1:0] rt;
      w = frame_w();
      h = frame_h();
      if (in_row >= h) return;   // last row still pending: ignored
      ic  = in_col;
      old = center_mem[ic];
      if (in_row >= 1) begin
         up = (in_row >= 2) ? upper_mem[ic] : '0;
         lf = (ic >= 1) ? left_ctr : '0;
         rt = (ic + 1 < w) ? center_mem[ic + 1] : '0;
         filtered_q.push_back(lap_pixel(old, up, pix, lf, rt, 1'b0));
         out_col = (out_col + 1 >= w) ? '0 : out_col + 1;
         upper_mem[ic] = old;
      end
      center_mem[ic] = pix;
      left_ctr       = old;
      in_col         = in_col + 1;
      if (in_col >= w) begin
         in_col = '0;
         in_row = in_row + 1;
      end
   endtask

   // Flush transaction: drains one pixel of the last row
   task automatic apply_flush();
      int               w;
      int               h;
      logic [ROW_W-1:0] oc;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] lf;
      logic [PIX_W-1:0] rt;
      logic             last;
      w = frame_w();
      h = frame_h();
      if (in_row < h) return;    // nothing pending
      oc   = out_col;
      up   = (h >= 2) ? upper_mem[oc] : '0;
      lf   = (oc >= 1) ? center_mem[oc - 1] : '0;
      rt   = (oc + 1 < w) ? center_mem[oc + 1] : '0;
      last = (oc + 1 >= w);
      filtered_q.push_back(lap_pixel(center_mem[oc], up, '0, lf, rt, last));
      if (last) restart_frame();
      else out_col = oc + 1;
   endtask

   task automatic log_fault(input string what, input rsp_type want, input rsp_type got);
      fault_cnt++;
      if (fault_cnt <= REPORT_LIMIT)
         $display("[%0t] %s: expected r=%02h g=%02h b=%02h eof=%0b, %s",
                  $time, what, want.red, want.green, want.blue, want.eof,
                  $sformatf("got r=%02h g=%02h b=%02h eof=%0b",
                            got.red, got.green, got.blue, got.eof));
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (filtered_q.size() == 0) begin
         log_fault("result with nothing expected", '0, got);
         return;
      end
      want = filtered_q.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.eof !== want.eof)
         log_fault("filtered pixel mismatch", want, got);
   endtask

   // Watch configuration writes, requests and results (all three channels) at each rising edge
   always @(posedge clock) begin : watch
      rsp_type got;
      if (reset) begin
         filtered_q.delete();
         restart_frame();
         cfg_width  = RESET_WIDTH;
         cfg_height = RESET_HEIGHT;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH: begin
                  cfg_width = csr_data;
                  restart_frame();
               end
               CSR_FRAME_HEIGHT: begin
                  cfg_height = csr_data;
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_opcode == OP_PIXEL) apply_pixel({req_red_in, req_green_in, req_blue_in});
            else apply_flush();
         end
         if (rsp_valid && rsp_ready) begin
            got.red   = rsp_red_out;
            got.green = rsp_green_out;
            got.blue  = rsp_blue_out;
            got.eof   = rsp_end_of_frame;
            check_result(got);
         end
      end
      expected_left <= filtered_q.size();
      fail_count    <= fault_cnt;
   end

endmodule

@@ tb/tb_laplacian_edge_filter_rgb.sv @@
// Top-level testbench for the RGB Laplacian edge filter: stimulus, idling, timeout and verdict.
`timescale 1ns / 100ps

module tb_laplacian_edge_filter_rgb;
   import lefr_pkg::*;

   localparam int LINE_DEPTH   = 2048;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1950;
   localparam int HOLD_CYCLES  = 400;

   // Indexes past the register list; the block ignores them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_opcode = OP_PIXEL;
   logic [CHAN_W-1:0]    req_red_in = '0;
   logic [CHAN_W-1:0]    req_green_in = '0;
   logic [CHAN_W-1:0]    req_blue_in = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CHAN_W-1:0]    rsp_red_out;
   logic [CHAN_W-1:0]    rsp_green_out;
   logic [CHAN_W-1:0]    rsp_blue_out;
   logic                 rsp_end_of_frame;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;

   int fail_count;
   int expected_left;
   int cycle_cnt = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_left = 0;
   bit hold_taken = 1'b0;
   bit hold_request = 1'b0;
   int cur_width = RESET_WIDTH;
   int cur_height = RESET_HEIGHT;
   int frame_items = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   laplacian_edge_filter_rgb #(.MAX_WIDTH(LINE_DEPTH)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   edge_filter_checker #(.MAX_WIDTH(LINE_DEPTH)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .expected_left    (expected_left)
   );

   // Result side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_taken) begin
         rsp_ready  <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [PIX_W-1:0] rand_pixel();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return '0;
      if (pick < 16) return '1;
      return PIX_W'($urandom());
   endfunction

   // One input transaction; valid stays up until accepted
   task automatic send_item(input logic op, input logic [PIX_W-1:0] pix);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_red_in   <= pix[16 +: 8];
      req_green_in <= pix[8 +: 8];
      req_blue_in  <= pix[0 +: 8];
      do @(posedge clock); while (!req_ready);
   endtask

   // Wait until every expected result is out and the pipeline has settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) cur_width = val;
      if (idx == CSR_FRAME_HEIGHT) cur_height = val;
   endtask

   task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
   endtask

   // Well-formed frame (pixels then drain), with optional ignored noise and early cut
   task automatic run_frame(input int cut_pct, input int noise_pct);
      int w;
      int h;
      int pixels;
      int total;
      int stop;
      int k;
      w = (cur_width == 0) ? 1 : (cur_width > LINE_DEPTH) ? LINE_DEPTH : cur_width;
      h = (cur_height == 0) ? 1 : cur_height;
      pixels = w * h;
      total  = pixels + w;
      stop   = ($urandom_range(99) < cut_pct) ? $urandom_range(total - 1) : total;
      for (k = 0; k < stop; k++) begin
         if ($urandom_range(99) < noise_pct)
            send_item((k < pixels) ? OP_FLUSH : OP_PIXEL, PIX_W'($urandom()));
         send_item((k < pixels) ? OP_PIXEL : OP_FLUSH, rand_pixel());
         frame_items++;
      end
   endtask

   initial begin : stimulus
      idle_mode_type mode;
      int            phase;
      int            f;
      int            w;
      int            h;
      int            pick;
      int            k;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: flush with nothing pending, under the reset geometry
      send_item(OP_FLUSH, 24'hFFFFFF);

      // 3x3 frame of mostly extreme pixels, an unused-index write in the middle
      set_frame(12'd3, 12'd3);
      send_item(OP_PIXEL, 24'hFFFFFF);
      send_item(OP_PIXEL, 24'h000000);
      send_item(OP_PIXEL, 24'hFF00FF);
      send_item(OP_PIXEL, 24'h00FF00);
      write_reg(CSR_SPARE_A, 12'hFFF);
      send_item(OP_PIXEL, 24'hFFFFFF);
      send_item(OP_PIXEL, 24'h000000);
      send_item(OP_PIXEL, 24'h123456);
      send_item(OP_PIXEL, 24'hFEDCBA);
      send_item(OP_PIXEL, 24'h80807F);
      send_item(OP_PIXEL, 24'h5A5A5A);   // last row pending: ignored
      send_item(OP_FLUSH, 24'h000000);
      send_item(OP_FLUSH, 24'hFFFFFF);
      send_item(OP_FLUSH, 24'hA5A5A5);   // end of frame
      send_item(OP_FLUSH, 24'hFFFFFF);   // nothing left to drain

      // Frame abandoned by a register write, then zero width and height
      set_frame(12'd2, 12'd2);
      send_item(OP_PIXEL, 24'h0000FF);
      send_item(OP_PIXEL, 24'hFF0000);
      send_item(OP_PIXEL, 24'h00FFFF);
      write_reg(CSR_FRAME_HEIGHT, 12'd0);
      write_reg(CSR_FRAME_WIDTH, 12'd0);
      write_reg(CSR_SPARE_B, 12'd0);
      send_item(OP_PIXEL, 24'hC3C3C3);
      send_item(OP_FLUSH, 24'h000000);

      // Widest row, held at the line depth: drain starts after LINE_DEPTH pixels
      set_frame(12'hFFF, 12'd1);
      for (k = 0; k < LINE_DEPTH + 4; k++) begin
         send_item((k < LINE_DEPTH) ? OP_PIXEL : OP_FLUSH, rand_pixel());
      end

      // Random frames, cycling through the idling phases
      frame_items = 0;
      phase = 0;
      while (frame_items < RANDOM_ITEMS) begin
         mode = idle_mode_type'(phase % 4);
         case (mode)
            IDLE_NONE: begin
               sender_idle_pct = 0;
               receiver_stall_pct <= 0;
            end
            IDLE_SENDER: begin
               sender_idle_pct = 76;
               receiver_stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
               sender_idle_pct = 0;
               receiver_stall_pct <= 76;
            end
            default: begin
               sender_idle_pct = 12;
               receiver_stall_pct <= 12;
            end
         endcase
         for (f = 0; f < 6; f++) begin
            pick = $urandom_range(99);
            if (pick < 5) w = 0;
            else if (pick < 75) w = $urandom_range(1, 8);
            else if (pick < 95) w = $urandom_range(9, 40);
            else w = $urandom_range(41, 200);
            pick = $urandom_range(99);
            if (pick < 5) h = 0;
            else if (w > 40) h = $urandom_range(1, 3);
            else if (pick < 80) h = $urandom_range(1, 5);
            else h = $urandom_range(6, 16);
            if (phase == 0 && f == 0) begin
               w = 16;
               h = 12;
            end
            set_frame(CFG_W'(w), CFG_W'(h));
            // Long result hold-off while the sender keeps going
            if (phase == 0 && f == 0) hold_request <= 1'b1;
            run_frame(10, 5);
         end
         phase++;
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ laplacian_edge_filter_rgb.f @@
hdl/lefr_pkg.sv
hdl/lefr_line_ram.sv
hdl/lefr_kernel.sv
hdl/lefr_out_fifo.sv
hdl/laplacian_edge_filter_rgb.sv
tb/edge_filter_checker.sv
tb/tb_laplacian_edge_filter_rgb.sv
